@@ rtl/lrup_pkg.sv @@
// ----------------------------------------------------------------------------
// lrup_pkg
// Shared constants, types and control bundles for the LRU page table.
// ----------------------------------------------------------------------------
package lrup_pkg;

  localparam int MAX_ENTRIES = 128;
  localparam int TIME_BITS   = 32;
  localparam int PAGE_BITS   = 16;

  // fixed port field widths
  localparam int PAGE_FIELD_W = 16;
  localparam int SLOT_FIELD_W = 7;
  localparam int HITS_W       = 32;
  localparam int CFG_W        = 8;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int MEM_W = PAGE_BITS + TIME_BITS;

  localparam logic [CFG_W-1:0] CFG_RESET = 8'd128;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [TIME_BITS-1:0] time_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_WRITE = 3'b100
  } state_t;

  typedef struct packed {
    logic  start;
    page_t page;
    cnt_t  size;
  } scan_req_t;

  typedef struct packed {
    logic  done;
    logic  hit;
    logic  evict;
    idx_t  slot;
    page_t old_page;
  } scan_res_t;

endpackage

@@ rtl/lrup_in_if.sv @@
// ----------------------------------------------------------------------------
// lrup_in_if
// Request channel: one page reference per request.
// ----------------------------------------------------------------------------
interface lrup_in_if;
  logic                               valid;
  logic                               ready;
  logic [lrup_pkg::PAGE_FIELD_W-1:0]  page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

@@ rtl/lrup_out_if.sv @@
// ----------------------------------------------------------------------------
// lrup_out_if
// Result channel: lookup outcome for each page reference.
// ----------------------------------------------------------------------------
interface lrup_out_if;
  logic                               valid;
  logic                               ready;
  logic                               hit;
  logic [lrup_pkg::SLOT_FIELD_W-1:0]  slot;
  logic                               evicted_valid;
  logic [lrup_pkg::PAGE_FIELD_W-1:0]  evicted_page;
  logic [lrup_pkg::HITS_W-1:0]        hit_count;
  logic                               time_saturated;

  modport source (output valid, output hit, output slot, output evicted_valid,
                  output evicted_page, output hit_count, output time_saturated,
                  input ready);
  modport sink   (input valid, input hit, input slot, input evicted_valid,
                  input evicted_page, input hit_count, input time_saturated,
                  output ready);
endinterface

@@ rtl/lru_page_replacement.sv @@
// ----------------------------------------------------------------------------
// lru_page_replacement
// Fully associative page table with timestamp-based LRU replacement.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one page reference per request; out_ch returns one result
//   per request: hit flag, slot, evicted page, running hit count and the
//   access counter saturation flag.
//   cfg_we/cfg_wdata set the active table size (0 acts as 1, values above
//   the table depth act as the depth). Write it only while the block is idle.
// Sequence:
//   After acceptance the active entries are read one per cycle from the
//   entry RAM (page and timestamp), then the chosen entry is written back.
//   A hit on entry i stops the scan early. The input is ready again once
//   the result is out, so a new request is accepted only after the
//   previous one has been written back.
// Reset:
//   All entries become empty, access counter and hit count clear, the table
//   size returns to 128. No clearing pass is needed.
// Stall:
//   The result is held in an output register; a new request is accepted while
//   it waits, but its write-back waits until that result is taken.
// ----------------------------------------------------------------------------
module lru_page_replacement (
  input  logic                         clk,
  input  logic                         rst_n,
  lrup_in_if.sink                      in_ch,
  lrup_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [lrup_pkg::CFG_W-1:0]   cfg_wdata
);

  lrup_pkg::state_t                   state_r, state_nxt;
  logic [lrup_pkg::CFG_W-1:0]         active_r;
  lrup_pkg::page_t                    page_r;
  lrup_pkg::time_t                    counter_r, counter_nxt;
  logic [lrup_pkg::HITS_W-1:0]        hits_r, hits_nxt;
  logic [lrup_pkg::MAX_ENTRIES-1:0]   valid_r;
  lrup_pkg::cnt_t                     size_c;

  logic                               out_valid_r;
  logic                               out_hit_r;
  logic [lrup_pkg::SLOT_FIELD_W-1:0]  out_slot_r;
  logic                               out_evict_r;
  logic [lrup_pkg::PAGE_FIELD_W-1:0]  out_epage_r;
  logic [lrup_pkg::HITS_W-1:0]        out_hits_r;
  logic                               out_sat_r;

  lrup_pkg::scan_req_t                scan_req;
  lrup_pkg::scan_res_t                scan_res;
  logic                               rd_en;
  lrup_pkg::idx_t                     rd_addr;
  logic [lrup_pkg::MEM_W-1:0]         rd_data;
  logic                               wr_en;
  logic                               in_acc;

  assign in_ch.ready = (state_r == lrup_pkg::S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign wr_en       = (state_r == lrup_pkg::S_WRITE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    if (active_r == '0) begin
      size_c = lrup_pkg::CNT_W'(1);
    end else if (32'(active_r) > 32'(lrup_pkg::MAX_ENTRIES)) begin
      size_c = lrup_pkg::CNT_W'(lrup_pkg::MAX_ENTRIES);
    end else begin
      size_c = lrup_pkg::CNT_W'(active_r);
    end
  end

  assign scan_req.start = in_acc;
  assign scan_req.page  = page_r;
  assign scan_req.size  = size_c;

  lrup_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (scan_req),
    .valid_vec (valid_r),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .res       (scan_res)
  );

  // entry word: {page, last use time}
  lrup_ram #(
    .WIDTH (lrup_pkg::MEM_W),
    .DEPTH (lrup_pkg::MAX_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (scan_res.slot),
    .wdata ({page_r, counter_r}),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lrup_pkg::S_IDLE: begin
        if (in_acc) state_nxt = lrup_pkg::S_SCAN;
      end
      lrup_pkg::S_SCAN: begin
        if (scan_res.done) state_nxt = lrup_pkg::S_WRITE;
      end
      lrup_pkg::S_WRITE: begin
        if (wr_en) state_nxt = lrup_pkg::S_IDLE;
      end
      default: state_nxt = lrup_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    counter_nxt = counter_r;
    if (counter_r != '1) begin
      counter_nxt = counter_r + 1'b1;
    end
    hits_nxt = hits_r;
    if (scan_res.hit && (hits_r != '1)) begin
      hits_nxt = hits_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lrup_pkg::S_IDLE;
      active_r    <= lrup_pkg::CFG_RESET;
      counter_r   <= '0;
      hits_r      <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        active_r <= cfg_wdata;
      end
      if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (wr_en) begin
        counter_r              <= counter_nxt;
        hits_r                 <= hits_nxt;
        valid_r[scan_res.slot] <= 1'b1;
        out_valid_r            <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      page_r <= lrup_pkg::PAGE_BITS'(in_ch.page_number);
    end
    if (wr_en) begin
      out_hit_r   <= scan_res.hit;
      out_slot_r  <= lrup_pkg::SLOT_FIELD_W'(scan_res.slot);
      out_evict_r <= scan_res.evict;
      out_epage_r <= scan_res.evict ? lrup_pkg::PAGE_FIELD_W'(scan_res.old_page) : '0;
      out_hits_r  <= hits_nxt;
      out_sat_r   <= (counter_nxt == '1);
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.hit            = out_hit_r;
  assign out_ch.slot           = out_slot_r;
  assign out_ch.evicted_valid  = out_evict_r;
  assign out_ch.evicted_page   = out_epage_r;
  assign out_ch.hit_count      = out_hits_r;
  assign out_ch.time_saturated = out_sat_r;

  // scan completes only while a request is being searched
  a_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    scan_res.done |-> (state_r == lrup_pkg::S_SCAN))
    else $error("scan done outside of search");

  // a hit always points at a resident entry
  a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && scan_res.hit) |-> valid_r[scan_res.slot])
    else $error("hit on an empty entry");

  // eviction only when the chosen slot already holds a page
  a_evict_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && scan_res.evict) |-> valid_r[scan_res.slot])
    else $error("eviction of an empty entry");

  // access counter never moves backward
  a_counter_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (counter_r >= $past(counter_r)))
    else $error("access counter decreased");

endmodule

@@ rtl/lrup_ram.sv @@
// ----------------------------------------------------------------------------
// lrup_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lrup_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/lrup_scan.sv @@
// ----------------------------------------------------------------------------
// lrup_scan
// Walks the active entries one per cycle: hit search, first empty entry and
// oldest timestamp are tracked in a single pass.
// ----------------------------------------------------------------------------
module lrup_scan (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  lrup_pkg::scan_req_t                  req,
  input  logic [lrup_pkg::MAX_ENTRIES-1:0]     valid_vec,
  output logic                                 rd_en,
  output lrup_pkg::idx_t                       rd_addr,
  input  logic [lrup_pkg::MEM_W-1:0]           rd_data,
  output lrup_pkg::scan_res_t                  res
);

  logic               busy_r,      busy_nxt;
  lrup_pkg::cnt_t     issue_r,     issue_nxt;
  logic               pend_r,      pend_nxt;
  lrup_pkg::idx_t     cmp_idx_r,   cmp_idx_nxt;
  logic               hit_r,       hit_nxt;
  lrup_pkg::idx_t     hit_idx_r,   hit_idx_nxt;
  logic               empty_r,     empty_nxt;
  lrup_pkg::idx_t     empty_idx_r, empty_idx_nxt;
  logic               old_any_r,   old_any_nxt;
  lrup_pkg::time_t    old_time_r,  old_time_nxt;
  lrup_pkg::idx_t     old_idx_r,   old_idx_nxt;
  lrup_pkg::page_t    old_page_r,  old_page_nxt;

  lrup_pkg::page_t    rd_page;
  lrup_pkg::time_t    rd_time;
  logic               done;
  logic               ent_valid;

  assign rd_page   = rd_data[lrup_pkg::MEM_W-1 -: lrup_pkg::PAGE_BITS];
  assign rd_time   = rd_data[lrup_pkg::TIME_BITS-1:0];
  assign ent_valid = valid_vec[cmp_idx_r];

  always_comb begin
    rd_en   = busy_r && !hit_r && (issue_r < req.size);
    rd_addr = issue_r[lrup_pkg::IDX_W-1:0];
    done    = busy_r && (hit_r || (!pend_r && (issue_r >= req.size)));

    busy_nxt      = busy_r;
    issue_nxt     = issue_r;
    pend_nxt      = rd_en;
    cmp_idx_nxt   = rd_addr;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    empty_nxt     = empty_r;
    empty_idx_nxt = empty_idx_r;
    old_any_nxt   = old_any_r;
    old_time_nxt  = old_time_r;
    old_idx_nxt   = old_idx_r;
    old_page_nxt  = old_page_r;

    if (rd_en) begin
      issue_nxt = issue_r + 1'b1;
    end

    // read data of a compare issued after a hit is dropped
    if (pend_r && !hit_r) begin
      if (ent_valid) begin
        if (rd_page == req.page) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = cmp_idx_r;
        end
        // strict less keeps the lowest index on ties
        if (!old_any_r || (rd_time < old_time_r)) begin
          old_any_nxt  = 1'b1;
          old_time_nxt = rd_time;
          old_idx_nxt  = cmp_idx_r;
          old_page_nxt = rd_page;
        end
      end else if (!empty_r) begin
        empty_nxt     = 1'b1;
        empty_idx_nxt = cmp_idx_r;
      end
    end

    if (done) begin
      busy_nxt = 1'b0;
    end

    if (req.start) begin
      busy_nxt    = 1'b1;
      issue_nxt   = '0;
      pend_nxt    = 1'b0;
      hit_nxt     = 1'b0;
      empty_nxt   = 1'b0;
      old_any_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      pend_r    <= 1'b0;
      hit_r     <= 1'b0;
      empty_r   <= 1'b0;
      old_any_r <= 1'b0;
      issue_r   <= '0;
    end else begin
      busy_r    <= busy_nxt;
      pend_r    <= pend_nxt;
      hit_r     <= hit_nxt;
      empty_r   <= empty_nxt;
      old_any_r <= old_any_nxt;
      issue_r   <= issue_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r   <= cmp_idx_nxt;
    hit_idx_r   <= hit_idx_nxt;
    empty_idx_r <= empty_idx_nxt;
    old_time_r  <= old_time_nxt;
    old_idx_r   <= old_idx_nxt;
    old_page_r  <= old_page_nxt;
  end

  always_comb begin
    res.done     = done;
    res.hit      = hit_r;
    res.evict    = !hit_r && !empty_r;
    res.old_page = old_page_r;
    if (hit_r) begin
      res.slot = hit_idx_r;
    end else if (empty_r) begin
      res.slot = empty_idx_r;
    end else begin
      res.slot = old_idx_r;
    end
  end

endmodule
